// ----- design/ucbs_pkg.sv -----
// Shared types and constants for the uniform cubic B-spline sampler.
// No dependencies; every other design file imports this package.
package ucbs_pkg;

  // Field widths
  localparam int COORD_W = 32;   // signed Q16.16 coordinate
  localparam int STEP_W  = 16;   // Q0.16 parameter step
  localparam int FRAC_W  = 16;   // fractional part of the parameter
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  // Shared multiplier and accumulator widths
  localparam int MUL_W  = 34;              // signed operand width
  localparam int PROD_W = 2 * MUL_W;       // full product
  localparam int ACC_W  = 66;              // sum of four 63-bit products
  localparam int Q_W    = 31;              // Q0.31 basis weight
  localparam int XD_W   = 33;              // rounded weight before divide by 3
  localparam int W_W    = 54;              // exact weight scaled by 6 * 2^48
  localparam int F2_W   = 32;              // frac squared
  localparam int F3_W   = 48;              // frac cubed

  // Weight rounding: floor((w + 3 * 2^17) / (3 * 2^18))
  localparam logic [W_W-1:0]   W_ROUND = W_W'(393216);
  // Reciprocal of three: floor(x * RECIP3 / 2^33) = floor(x / 3) for x < 2^33
  localparam logic [31:0]      RECIP3  = 32'hAAAA_AAAB;
  localparam int               RECIP_SH = 33;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(655);

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOCURVE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] ST_ACK     = 2'd3;

  // Accumulator control from the sequencer
  typedef struct packed {
    logic load;   // acc takes the product
    logic add;    // acc adds the product
  } mac_ctl_t;

endpackage

// ----- design/ucbs_req_if.sv -----
// Request channel of the B-spline sampler: valid/ready plus command and point.
// Depends on ucbs_pkg.
interface ucbs_req_if;
  import ucbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CMD_W-1:0]          cmd;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;

  modport source (output valid, output cmd, output point_x, output point_y, input ready);
  modport sink   (input valid, input cmd, input point_x, input point_y, output ready);
endinterface

// ----- design/ucbs_res_if.sv -----
// Result channel of the B-spline sampler: valid/ready plus sample and status.
// Depends on ucbs_pkg.
interface ucbs_res_if;
  import ucbs_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] curve_x;
  logic signed [COORD_W-1:0] curve_y;
  logic                      last_sample;
  logic [STAT_W-1:0]         status;

  modport source (output valid, output curve_x, output curve_y, output last_sample,
                  output status, input ready);
  modport sink   (input valid, input curve_x, input curve_y, input last_sample,
                  input status, output ready);
endinterface

// ----- design/ucbs_mac.sv -----
// Shared signed multiplier with registered product, accumulator, and the
// round-to-Q16.16 and saturate stage. Depends on ucbs_pkg.
module ucbs_mac (
  input  logic                              clk,
  input  ucbs_pkg::mac_ctl_t                ctl,
  input  logic signed [ucbs_pkg::MUL_W-1:0] a,
  input  logic signed [ucbs_pkg::MUL_W-1:0] b,
  output logic signed [ucbs_pkg::PROD_W-1:0] prod,
  output logic signed [ucbs_pkg::COORD_W-1:0] result
);
  import ucbs_pkg::*;

  localparam int R_W = ACC_W - 31;

  logic signed [ACC_W-1:0] acc;
  logic [ACC_W-1:0]        acc_rnd;
  logic [R_W-1:0]          r;

  // Multiply every cycle; the sequencer picks what it needs
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Load or add the product
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc <= prod[ACC_W-1:0];
    end else if (ctl.add) begin
      acc <= acc + prod[ACC_W-1:0];
    end
  end

  // Round half up at bit 31, then saturate to 32 bits
  assign acc_rnd = acc + (ACC_W'(1) << 30);
  assign r       = acc_rnd[ACC_W-1:31];

  always_comb begin
    if (r[R_W-1:COORD_W-1] == '0 || r[R_W-1:COORD_W-1] == '1) begin
      result = r[COORD_W-1:0];
    end else if (r[R_W-1]) begin
      result = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(COORD_W-1){1'b1}}};
    end
  end

endmodule

// ----- design/uniform_cubic_bspline_sampler_top.sv -----
// Top level of the uniform cubic B-spline sampler: point store, sequencer
// and weight logic. Depends on ucbs_pkg, ucbs_req_if, ucbs_res_if, ucbs_mac.

// A request is taken when the block is idle. Clear, append and any request
// that yields no curve go from acceptance straight to the finish state; a
// sample first runs one shared 34x34 multiplier through frac squared and
// cubed, four divides by three through a reciprocal, and four point
// products per coordinate, while the four control points are read from the
// store. The result sits in an output register, so the next request is taken
// while it waits; a finished request holds until the previous result is
// taken. Points live in a MAX_POINTS x 64 memory; only entries below the
// point count are used in a sample.
module uniform_cubic_bspline_sampler_top #(
  parameter int MAX_POINTS = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [ucbs_pkg::STEP_W-1:0]    cfg_data,
  ucbs_req_if.sink                       req,
  ucbs_res_if.source                     res
);
  import ucbs_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] CALC_LAST = 5'd15;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;
  logic [4:0] step;

  // Control and architectural state
  logic [CW-1:0]     point_count;
  logic [CW-1:0]     param_int;
  logic [FRAC_W-1:0] param_frac;
  logic [STEP_W-1:0] param_step;
  logic              do_smp;
  logic              out_valid;

  // Latched request
  logic [CMD_W-1:0]          cmd_r;
  logic signed [COORD_W-1:0] px_in;
  logic signed [COORD_W-1:0] py_in;

  // Point store
  logic [2*COORD_W-1:0] mem [MAX_POINTS];
  logic [2*COORD_W-1:0] rdata;
  logic [AW-1:0]        raddr;
  logic                 mem_we;

  // Datapath registers
  logic [F2_W-1:0]           f2_r;
  logic [XD_W-1:0]           xd [4];
  logic [Q_W-1:0]            q [4];
  logic signed [COORD_W-1:0] pt_x [4];
  logic signed [COORD_W-1:0] pt_y [4];
  logic signed [COORD_W-1:0] cx_r;

  // Shared unit
  mac_ctl_t                  mac_ctl;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [COORD_W-1:0] mac_res;

  // Weight terms
  logic [F3_W-1:0] f3;
  logic [W_W-1:0]  f3e, f2s, f1s, w0, w1, w2, w3;

  logic            req_go;
  logic            smp_ok;
  logic            fin_go;
  logic [FRAC_W:0] nf;
  logic [CW-1:0]   ni;

  assign req.ready = (state == S_IDLE);
  assign req_go    = req.valid && req.ready;
  assign smp_ok    = (req.cmd == CMD_SAMPLE) && (point_count >= CW'(4))
                     && (param_int < point_count);
  assign fin_go    = (state == S_FIN) && (!out_valid || res.ready);

  // Next parameter for sample completion
  assign nf = {1'b0, param_frac} + {1'b0, param_step};
  assign ni = param_int + CW'(nf[FRAC_W]);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          step <= '0;
          if (req_go) begin
            state <= smp_ok ? S_CALC : S_FIN;
          end
        end
        S_CALC: begin
          step <= step + 5'd1;
          if (step == CALC_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (req_go) begin
      cmd_r <= req.cmd;
      px_in <= req.point_x;
      py_in <= req.point_y;
    end
  end

  // Architectural state: step written via cfg, curve state updated when the result is handed over
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
      param_int   <= CW'(3);
      param_frac  <= '0;
      param_step  <= STEP_RESET;
      do_smp      <= 1'b0;
    end else begin
      if (cfg_we) begin
        param_step <= cfg_data;
      end
      if (req_go) begin
        do_smp <= smp_ok;
      end
      if (fin_go) begin
        if (do_smp) begin
          param_frac <= nf[FRAC_W-1:0];
          param_int  <= ni;
        end else if (cmd_r == CMD_CLEAR) begin
          point_count <= '0;
          param_int   <= CW'(3);
          param_frac  <= '0;
        end else if (cmd_r == CMD_APPEND && point_count < CW'(MAX_POINTS)) begin
          point_count <= point_count + CW'(1);
        end
      end
    end
  end

  // Point store: append writes, four sequential reads per sample
  assign mem_we = fin_go && !do_smp && (cmd_r == CMD_APPEND)
                  && (point_count < CW'(MAX_POINTS));
  assign raddr  = AW'(param_int - CW'(3) + CW'(step[1:0]));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[point_count[AW-1:0]] <= {px_in, py_in};
    end
    rdata <= mem[raddr];
  end

  // Capture the four control points
  always_ff @(posedge clk) begin
    if (state == S_CALC && step >= 5'd1 && step <= 5'd4) begin
      pt_x[2'(step - 5'd1)] <= rdata[2*COORD_W-1:COORD_W];
      pt_y[2'(step - 5'd1)] <= rdata[COORD_W-1:0];
    end
  end

  // Exact basis weights scaled by 6 * 2^48
  assign f3  = prod[F3_W-1:0];
  assign f3e = W_W'(f3);
  assign f2s = W_W'(f2_r) << 16;
  assign f1s = W_W'(param_frac) << 32;
  assign w0  = (W_W'(1) << 48) - 3 * f1s + 3 * f2s - f3e;
  assign w1  = 3 * f3e - 6 * f2s + (W_W'(1) << 50);
  assign w2  = 3 * f2s + 3 * f1s + (W_W'(1) << 48) - 3 * f3e;
  assign w3  = f3e;

  // Powers of frac, rounded weights, weights divided by three, and the x result
  always_ff @(posedge clk) begin
    if (state == S_CALC) begin
      if (step == 5'd1) begin
        f2_r <= prod[F2_W-1:0];
      end
      if (step == 5'd2) begin
        xd[0] <= XD_W'((w0 + W_ROUND) >> 18);
        xd[1] <= XD_W'((w1 + W_ROUND) >> 18);
        xd[2] <= XD_W'((w2 + W_ROUND) >> 18);
        xd[3] <= XD_W'((w3 + W_ROUND) >> 18);
      end
      if (step >= 5'd4 && step <= 5'd7) begin
        q[2'(step - 5'd4)] <= prod[RECIP_SH+Q_W-1:RECIP_SH];
      end
      if (step == 5'd12) begin
        cx_r <= mac_res;
      end
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CALC) begin
      case (step) inside
        5'd0: begin
          mul_a = MUL_W'(param_frac);
          mul_b = MUL_W'(param_frac);
        end
        5'd1: begin
          mul_a = MUL_W'(prod[F2_W-1:0]);
          mul_b = MUL_W'(param_frac);
        end
        [5'd3:5'd6]: begin
          mul_a = MUL_W'(xd[2'(step - 5'd3)]);
          mul_b = MUL_W'(RECIP3);
        end
        [5'd7:5'd10]: begin
          mul_a = MUL_W'(q[2'(step - 5'd7)]);
          mul_b = MUL_W'(pt_x[2'(step - 5'd7)]);
        end
        [5'd11:5'd14]: begin
          mul_a = MUL_W'(q[2'(step - 5'd11)]);
          mul_b = MUL_W'(pt_y[2'(step - 5'd11)]);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  // Accumulate x products, then y products
  always_comb begin
    mac_ctl = '0;
    if (state == S_CALC) begin
      case (step) inside
        5'd8, 5'd12:                 mac_ctl.load = 1'b1;
        [5'd9:5'd11], [5'd13:5'd15]: mac_ctl.add  = 1'b1;
        default:                     mac_ctl = '0;
      endcase
    end
  end

  ucbs_mac u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .a      (mul_a),
    .b      (mul_b),
    .prod   (prod),
    .result (mac_res)
  );

  // Output register: valid held until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      res.curve_x     <= '0;
      res.curve_y     <= '0;
      res.last_sample <= 1'b0;
      if (do_smp) begin
        res.curve_x     <= cx_r;
        res.curve_y     <= mac_res;
        res.last_sample <= (ni >= point_count);
        res.status      <= ST_OK;
      end else if (cmd_r == CMD_CLEAR) begin
        res.status <= ST_ACK;
      end else if (cmd_r == CMD_APPEND) begin
        res.status <= (point_count < CW'(MAX_POINTS)) ? ST_ACK : ST_FULL;
      end else begin
        res.status <= ST_NOCURVE;
      end
    end
  end

  assign res.valid = out_valid;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the uniform cubic B-spline sampler: drives clear,
// append, sample and unused requests and checks every reply against a built-in model.
// Depends on ucbs_pkg, ucbs_req_if, ucbs_res_if and uniform_cubic_bspline_sampler_top.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ucbs_pkg::*;

  localparam int MAX_PTS      = 256;
  localparam int RUN_LIMIT    = 600000;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTS   = 40;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      last_sample;
    logic [STAT_W-1:0]         status;
  } reply_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [STEP_W-1:0] cfg_data;

  ucbs_req_if req_ch ();
  ucbs_res_if res_ch ();

  uniform_cubic_bspline_sampler_top #(.MAX_POINTS(MAX_PTS)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_ch),
    .res      (res_ch)
  );

  // Model state: point store, running parameter and step
  logic signed [COORD_W-1:0] pts_x [0:MAX_PTS-1];
  logic signed [COORD_W-1:0] pts_y [0:MAX_PTS-1];
  int n_pts;
  int u_int;
  int u_frac;
  int step_val;

  reply_t sampler_replies [$];
  int error_count = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int hold_cycles = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  always #1 clk = ~clk;

  // Round a Q0.31-weighted sum back to Q16.16 and saturate
  function automatic logic signed [COORD_W-1:0] round_q31(longint acc);
    longint v;
    v = (acc + (longint'(1) <<< 30)) >>> 31;
    if (v > S32_MAX) v = S32_MAX;
    if (v < S32_MIN) v = S32_MIN;
    return v[31:0];
  endfunction

  // Apply one request to the model state and return the reply it yields
  function automatic reply_t apply_command(logic [CMD_W-1:0] c,
                                           logic signed [COORD_W-1:0] x,
                                           logic signed [COORD_W-1:0] y);
    reply_t r;
    longint f, g, ax, ay;
    longint wt [4];
    longint q [4];
    int nf, ni;
    r = '0;
    r.status = ST_NOCURVE;
    if (c == CMD_CLEAR) begin
      n_pts = 0;
      u_int = 3;
      u_frac = 0;
      r.status = ST_ACK;
    end else if (c == CMD_APPEND) begin
      if (n_pts < MAX_PTS) begin
        pts_x[n_pts] = x;
        pts_y[n_pts] = y;
        n_pts++;
        r.status = ST_ACK;
      end else begin
        r.status = ST_FULL;
      end
    end else if (c == CMD_SAMPLE && n_pts >= 4 && u_int < n_pts) begin
      f = u_frac;
      g = 65536 - f;
      // basis weights scaled by 6 * 2^48
      wt[0] = g * g * g;
      wt[1] = 3 * f * f * f - 6 * f * f * 65536 + 4 * (longint'(1) <<< 48);
      wt[2] = -3 * f * f * f + 3 * f * f * 65536 + 3 * f * (longint'(1) <<< 32)
              + (longint'(1) <<< 48);
      wt[3] = f * f * f;
      ax = 0;
      ay = 0;
      for (int k = 0; k < 4; k++) begin
        q[k] = (wt[k] + 393216) / 786432;
        ax += q[k] * longint'(pts_x[u_int - 3 + k]);
        ay += q[k] * longint'(pts_y[u_int - 3 + k]);
      end
      r.curve_x = round_q31(ax);
      r.curve_y = round_q31(ay);
      // advance the parameter
      nf = u_frac + step_val;
      ni = u_int + (nf >> 16);
      u_frac = nf & 16'hFFFF;
      u_int = ni;
      r.last_sample = (ni >= n_pts);
      r.status = ST_OK;
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord(bit extreme);
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(0, extreme ? 1 : 9))
      0:       v = COORD_MAX;
      1:       v = COORD_MIN;
      2:       v = '0;
      3:       v = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Pick a step: mostly random, sometimes the extremes
  function automatic logic [STEP_W-1:0] pick_step();
    logic [STEP_W-1:0] s;
    case ($urandom_range(0, 3))
      0:       s = STEP_W'($urandom_range(1, 300));
      1:       s = STEP_W'($urandom_range(300, 8000));
      2:       s = STEP_W'($urandom_range(8000, 65535));
      default: s = ($urandom_range(0, 1) == 0) ? 16'd1 : 16'hFFFF;
    endcase
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                 logic [COORD_W-1:0] want);
    if (error_count < MAX_PRINTS)
      $display("MISMATCH %s: got %08h want %08h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  // Offer one request; return at the edge where it is accepted, valid left high
  task automatic send_request(logic [CMD_W-1:0] c, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    req_ch.valid   <= 1'b1;
    req_ch.cmd     <= c;
    req_ch.point_x <= x;
    req_ch.point_y <= y;
    @(negedge clk);
    while (!req_ch.ready) @(negedge clk);
    @(posedge clk);
    sampler_replies.insert(sampler_replies.size(), apply_command(c, x, y));
    items_sent++;
  endtask

  // Drop valid and hold until every predicted reply has been taken
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (sampler_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(logic [STEP_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    step_val = int'(v);
  endtask

  task automatic append_points(int n, bit extreme);
    repeat (n) send_request(CMD_APPEND, rand_coord(extreme), rand_coord(extreme));
  endtask

  // Empty store, unused command, too few points, then a live curve at reset step
  task automatic test_empty_and_few_points();
    send_request(CMD_SAMPLE, '0, '0);
    send_request(CMD_UNUSED, $urandom, $urandom);
    send_request(CMD_APPEND, COORD_MAX, COORD_MIN);
    send_request(CMD_APPEND, COORD_MIN, COORD_MAX);
    send_request(CMD_APPEND, '0, -32'sd1);
    send_request(CMD_SAMPLE, '0, '0);
    send_request(CMD_APPEND, 32'sh0001_0000, -32'sh0001_0000);
    send_request(CMD_SAMPLE, '0, '0);
    send_request(CMD_SAMPLE, '0, '0);
  endtask

  // Zero step freezes the parameter; smallest nonzero step moves it by one lsb
  task automatic test_zero_step();
    wait_idle();
    write_step(16'd0);
    send_request(CMD_SAMPLE, '0, '0);
    send_request(CMD_SAMPLE, '0, '0);
    wait_idle();
    write_step(16'd1);
    send_request(CMD_SAMPLE, '0, '0);
  endtask

  // Run off the end of a saturating curve, then resume with one more point
  task automatic test_finish_and_resume();
    wait_idle();
    write_step(16'hFFFF);
    send_request(CMD_CLEAR, $urandom, $urandom);
    repeat (4) send_request(CMD_APPEND, COORD_MAX, COORD_MIN);
    repeat (3) send_request(CMD_SAMPLE, '0, '0);
    send_request(CMD_APPEND, COORD_MIN, COORD_MAX);
    repeat (2) send_request(CMD_SAMPLE, '0, '0);
  endtask

  // Fill the store, overflow it, and walk the whole curve
  task automatic test_store_full();
    wait_idle();
    write_step(STEP_W'($urandom_range(49152, 65535)));
    send_request(CMD_CLEAR, '0, '0);
    append_points(MAX_PTS + 2, 1'b0);
    while (u_int < n_pts) send_request(CMD_SAMPLE, '0, '0);
    send_request(CMD_SAMPLE, '0, '0);
  endtask

  // Hold the reply side off while requests keep coming, then let it drain
  task automatic test_backpressure();
    wait_idle();
    write_step(STEP_W'($urandom_range(1, 2000)));
    send_request(CMD_CLEAR, '0, '0);
    append_points(8, 1'b0);
    hold_cycles = 300;
    repeat (20) send_request(CMD_SAMPLE, '0, '0);
    wait_idle();
  endtask

  // Random phases: a fresh curve per phase, mostly appends and samples
  task automatic test_random_phases(int target, bit quiet);
    int phase_len;
    int r;
    bit extreme;
    while (items_sent < target) begin
      // keep the request stream unbroken in the quiet part
      if (!quiet) begin
        wait_idle();
        write_step(pick_step());
      end
      gaps_on   = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      stalls_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
      extreme   = ($urandom_range(0, 5) == 0);
      send_request(CMD_CLEAR, $urandom, $urandom);
      append_points(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3)
                                                : $urandom_range(4, 10), extreme);
      phase_len = $urandom_range(60, 160);
      for (int i = 0; i < phase_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 25)
          send_request(CMD_APPEND, rand_coord(extreme), rand_coord(extreme));
        else if (r < 90)
          send_request(CMD_SAMPLE, $urandom, $urandom);
        else if (r < 97)
          send_request(CMD_UNUSED, $urandom, $urandom);
        else
          send_request(CMD_CLEAR, $urandom, $urandom);
      end
    end
  endtask

  // Reply side: long hold-off, random stall bursts, otherwise ready
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      res_ch.ready <= 1'b0;
      hold_cycles--;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left = $urandom_range(0, 9);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compare each reply taken at the coming edge with the oldest prediction
  always @(negedge clk) begin
    reply_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (sampler_replies.size() == 0) begin
        report_mismatch("unexpected reply, status", 32'(res_ch.status), '0);
      end else begin
        want = sampler_replies.pop_front();
        if (res_ch.curve_x !== want.curve_x)
          report_mismatch("curve_x", res_ch.curve_x, want.curve_x);
        if (res_ch.curve_y !== want.curve_y)
          report_mismatch("curve_y", res_ch.curve_y, want.curve_y);
        if (res_ch.last_sample !== want.last_sample)
          report_mismatch("last_sample", 32'(res_ch.last_sample), 32'(want.last_sample));
        if (res_ch.status !== want.status)
          report_mismatch("status", 32'(res_ch.status), 32'(want.status));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_CLEAR;
    req_ch.point_x = '0;
    req_ch.point_y = '0;
    res_ch.ready = 1'b0;
    n_pts = 0;
    u_int = 3;
    u_frac = 0;
    step_val = int'(STEP_RESET);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_and_few_points();
    test_zero_step();
    test_finish_and_resume();
    test_store_full();
    test_backpressure();
    test_random_phases(1400, 1'b0);
    test_random_phases(1620, 1'b1);

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- uniform_cubic_bspline_sampler_top.f -----
design/ucbs_pkg.sv
design/ucbs_req_if.sv
design/ucbs_res_if.sv
design/ucbs_mac.sv
design/uniform_cubic_bspline_sampler_top.sv
verif/tb_top.sv
